/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define SCRF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scrf assertion failed");

// next-cycle implication, masked while reset is high
`define SCRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scrf assertion failed");

// next-cycle implication that also holds across reset
`define SCRF_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scrf assertion failed");

`endif

/* src/scrf_pkg.sv */
// shared types and constants of the system controller register file
package scrf_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TRAY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_READ  = 2'd1,
    ST_BAD_WRITE = 2'd2,
    ST_NO_INT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_VERSION0 = 2'd0,
    CFG_VERSION1 = 2'd1,
    CFG_VERSION2 = 2'd2,
    CFG_VIDEO    = 2'd3
  } cfg_index_t;

  // controller register codes
  localparam logic [7:0] REG_VERSION   = 8'h01;
  localparam logic [7:0] REG_TRAY      = 8'h03;
  localparam logic [7:0] REG_VIDEO     = 8'h04;
  localparam logic [7:0] REG_FAN_MODE  = 8'h05;
  localparam logic [7:0] REG_FAN_SPEED = 8'h06;
  localparam logic [7:0] REG_LED_OVR   = 8'h07;
  localparam logic [7:0] REG_LED_STATE = 8'h08;
  localparam logic [7:0] REG_CPU_TEMP  = 8'h09;
  localparam logic [7:0] REG_MB_TEMP   = 8'h0A;
  localparam logic [7:0] REG_SCR_READ  = 8'h0F;
  localparam logic [7:0] REG_FAN_READ  = 8'h10;
  localparam logic [7:0] REG_SCRATCH   = 8'h1B;

  localparam logic [7:0] FAN_SPEED_MAX  = 8'd50;
  localparam logic [7:0] TRAY_MEDIA_DET = 8'h60;
  localparam logic [2:0] VIDEO_HDTV     = 3'd1;
  localparam logic [1:0] VERSION_LAST   = 2'd2;

  typedef struct packed {
    logic [7:0] version0;
    logic [7:0] version1;
    logic [7:0] version2;
    logic [2:0] video_mode;
  } cfg_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] reg_code;
    logic [7:0] write_value;
    logic [7:0] new_tray_state;
    logic       raise_interrupt;
    logic [7:0] cpu_temperature;
    logic [7:0] board_temperature;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
  } result_t;

endpackage

/* src/scrf_if.sv */
// valid/ready channel interfaces: request, response and configuration write

interface scrf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] reg_code;
  logic [7:0] write_value;
  logic [7:0] new_tray_state;
  logic       raise_interrupt;
  logic [7:0] cpu_temperature;
  logic [7:0] board_temperature;

  modport source (output valid, command, reg_code, write_value, new_tray_state,
                  raise_interrupt, cpu_temperature, board_temperature,
                  input ready);
  modport sink (input valid, command, reg_code, write_value, new_tray_state,
                raise_interrupt, cpu_temperature, board_temperature,
                output ready);
endinterface

interface scrf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

interface scrf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/scrf_regs.sv */
// configuration registers: version bytes and video mode
module scrf_regs (
  input  logic           clk,
  input  logic           rst,
  scrf_cfg_if.sink       cfg,
  output scrf_pkg::cfg_t regs
);
  import scrf_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.version0   <= '0;
      regs.version1   <= '0;
      regs.version2   <= '0;
      regs.video_mode <= VIDEO_HDTV;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_VERSION0: regs.version0   <= cfg.data;
        CFG_VERSION1: regs.version1   <= cfg.data;
        CFG_VERSION2: regs.version2   <= cfg.data;
        CFG_VIDEO:    regs.video_mode <= cfg.data[2:0];
        default: ;
      endcase
    end
  end
endmodule

/* src/scrf_core.sv */
// register access logic and controller state, one access per step
module scrf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  scrf_pkg::item_t   item,
  input  scrf_pkg::cfg_t    regs,
  output scrf_pkg::result_t result
);
  import scrf_pkg::*;

  logic [1:0] version_index, version_index_next;
  logic       fan_mode_bit, fan_mode_bit_next;
  logic [5:0] fan_speed_level, fan_speed_level_next;
  logic [7:0] tray_status, tray_status_next;
  logic [7:0] version_byte;

  always_comb begin
    case (version_index)
      2'd1:    version_byte = regs.version1;
      2'd2:    version_byte = regs.version2;
      default: version_byte = regs.version0;
    endcase
  end

  // led override and led pattern have no read path, so those writes are only acknowledged
  always_comb begin
    result.read_data     = '0;
    result.status        = ST_OK;
    version_index_next   = version_index;
    fan_mode_bit_next    = fan_mode_bit;
    fan_speed_level_next = fan_speed_level;
    tray_status_next     = tray_status;
    case (item.command)
      CMD_READ: begin
        case (item.reg_code)
          REG_VERSION: begin
            result.read_data   = version_byte;
            version_index_next = (version_index == VERSION_LAST) ? 2'd0
                                                                 : version_index + 2'd1;
          end
          REG_TRAY:     result.read_data = tray_status;
          REG_VIDEO:    result.read_data = {5'd0, regs.video_mode};
          REG_CPU_TEMP: result.read_data = item.cpu_temperature;
          REG_MB_TEMP:  result.read_data = item.board_temperature;
          REG_SCR_READ, REG_SCRATCH: result.read_data = '0;
          REG_FAN_READ: result.read_data = fan_mode_bit ? {2'd0, fan_speed_level} : 8'd0;
          default:      result.status = ST_BAD_READ;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_code)
          REG_VERSION: begin
            if (item.write_value == 8'd0) version_index_next = 2'd0;
          end
          REG_FAN_MODE: fan_mode_bit_next = item.write_value[0];
          REG_FAN_SPEED: begin
            if (item.write_value <= FAN_SPEED_MAX) begin
              fan_speed_level_next = item.write_value[5:0];
            end
          end
          REG_LED_OVR, REG_LED_STATE: ;
          default: result.status = ST_BAD_WRITE;
        endcase
      end
      CMD_TRAY: begin
        tray_status_next = item.new_tray_state;
        if (item.raise_interrupt) result.status = ST_NO_INT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_index   <= '0;
      fan_mode_bit    <= 1'b0;
      fan_speed_level <= '0;
      tray_status     <= TRAY_MEDIA_DET;
    end else if (step) begin
      version_index   <= version_index_next;
      fan_mode_bit    <= fan_mode_bit_next;
      fan_speed_level <= fan_speed_level_next;
      tray_status     <= tray_status_next;
    end
  end
endmodule

/* src/system_controller_register_file_top.sv */
// top level of the system controller register file
//
// channels: req carries one register read, register write or tray update per
// beat; rsp returns one beat per request with read_data and status; cfg writes
// the version bytes (index 0 to 2) and the video mode (index 3), and is always
// ready. the user must change configuration only while no request is in
// flight; the block does not enforce it. a request accepted passes through
// the input register, then the result register, before it shows on rsp.
// throughput: one request per cycle with rsp ready; the access logic between
// the input and result registers is a single level of muxing and compares.
// stall: while rsp is held, the result register keeps its beat and one more
// request may sit in the input register; req.ready drops once both are full.
// reset: synchronous, active high; both stages empty, req not ready during
// reset, version index 0, fan mode and speed 0, tray status 0x60, video
// mode 1, version bytes 0.
module system_controller_register_file_top (
  input logic      clk,
  input logic      rst,
  scrf_req_if.sink req,
  scrf_rsp_if.source rsp,
  scrf_cfg_if.sink cfg
);
  import scrf_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  cfg_t    regs;
  logic    advance;
  logic    req_beat;

  // input stage moves on when the result register is empty or draining
  assign advance  = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || advance);
  assign req_beat = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_beat) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (req_beat) begin
      s1_item.command           <= cmd_t'(req.command);
      s1_item.reg_code          <= req.reg_code;
      s1_item.write_value       <= req.write_value;
      s1_item.new_tray_state    <= req.new_tray_state;
      s1_item.raise_interrupt   <= req.raise_interrupt;
      s1_item.cpu_temperature   <= req.cpu_temperature;
      s1_item.board_temperature <= req.board_temperature;
    end
  end

  scrf_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // state updates take effect as the item leaves the input stage
  scrf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .regs   (regs),
    .result (core_result)
  );

  // result register, holds its beat while rsp is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_result.read_data;
  assign rsp.status    = out_result.status;
endmodule

/* src/scrf_checker.sv */
// port-level checker for the register file top, bound to the top level
`include "assert_macros.svh"

module scrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_data,
  input logic [1:0] rsp_status
);
  import scrf_pkg::*;

  // only an ok status carries data
  `SCRF_ASSERT_NOW(a_data_only_ok, clk, rst, rsp_valid && (rsp_read_data != 8'd0), rsp_status == ST_OK)

  // a fresh response traces back to its request beat through the input register and then the result register
  `SCRF_ASSERT_NOW(a_rsp_latency, clk, rst, $rose(rsp_valid), $past(req_valid && req_ready, 2))

  // a stalled response beat holds
  `SCRF_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))

  // reset empties the response side
  `SCRF_ASSERT_ALWAYS(a_rst_empty, clk, rst, !rsp_valid)
endmodule

bind system_controller_register_file_top scrf_checker u_scrf_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data),
  .rsp_status    (rsp.status)
);
